// ===== rtl/wat_pkg.sv =====
package wat_pkg;

  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int DAYS_W   = 7;
  localparam int WDAY_W   = 3;
  localparam int ID_W     = 5;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;
  localparam int MASK_W   = 16;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [DAYS_W-1:0]   days;
    logic                rep;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
  } wat_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic issue;
    logic finish;
  } wat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk;
    logic last;
  } wat_sts_t;

endpackage

// ===== rtl/weekday_alarm_table_top.sv =====
// Weekday alarm table: a compacted list of up to TABLE_DEPTH alarms.
// Command channel: drive op and its operand fields with start high; the beat
// is taken at a clock edge where start is high and busy is low. The fields are
// captured at that edge and need not be held afterwards.
// Result channel: done is high for exactly one cycle while status, new_id,
// ring_mask, ring_count and alarm_count hold the result; the receiver must
// take it in that cycle, as it cannot hold results off.
// Sequence: create and unused ops go from decode straight to drain and response.
// A check over n held entries, and a delete that moves n later entries down,
// walks the table one entry a cycle through its single read port between
// decode and drain. busy falls in the cycle after done.
// Reset: rst clears the entry count to zero and returns the controller to
// idle; table contents are only read below the entry count.
module weekday_alarm_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [wat_pkg::OP_W-1:0]          op,
  input  logic [wat_pkg::HOUR_W-1:0]        hour,
  input  logic [wat_pkg::MINUTE_W-1:0]      minute,
  input  logic                              repeat_req,
  input  logic [wat_pkg::DAYS_W-1:0]        day_mask,
  input  logic [wat_pkg::ID_W-1:0]          alarm_id,
  input  logic [wat_pkg::WDAY_W-1:0]        weekday,
  output logic                              done,
  output logic [wat_pkg::STATUS_W-1:0]      status,
  output logic [wat_pkg::ID_W-1:0]          new_id,
  output logic [wat_pkg::MASK_W-1:0]        ring_mask,
  output logic [wat_pkg::ID_W-1:0]          ring_count,
  output logic [wat_pkg::ID_W-1:0]          alarm_count
);

  wat_pkg::wat_cmd_t cmd;
  wat_pkg::wat_sts_t sts;

  wat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  wat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .hour        (hour),
    .minute      (minute),
    .repeat_req  (repeat_req),
    .day_mask    (day_mask),
    .alarm_id    (alarm_id),
    .weekday     (weekday),
    .status      (status),
    .new_id      (new_id),
    .ring_mask   (ring_mask),
    .ring_count  (ring_count),
    .alarm_count (alarm_count)
  );

endmodule

// ===== rtl/wat_ctrl.sv =====
module wat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  wat_pkg::wat_sts_t sts,
  output wat_pkg::wat_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_WALK   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = sts.walk ? S_WALK : S_DRAIN;
      end
      S_WALK: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last entry read in the walk is consumed in this cycle.
        cmd.finish = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_RESP);

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state is not one-hot");

  a_resp_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |-> ($past(state) == S_DRAIN))
    else $error("response without a preceding drain cycle");

endmodule

// ===== rtl/wat_dp.sv =====
module wat_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wat_pkg::wat_cmd_t                 cmd,
  output wat_pkg::wat_sts_t                 sts,
  input  logic [wat_pkg::OP_W-1:0]          op,
  input  logic [wat_pkg::HOUR_W-1:0]        hour,
  input  logic [wat_pkg::MINUTE_W-1:0]      minute,
  input  logic                              repeat_req,
  input  logic [wat_pkg::DAYS_W-1:0]        day_mask,
  input  logic [wat_pkg::ID_W-1:0]          alarm_id,
  input  logic [wat_pkg::WDAY_W-1:0]        weekday,
  output logic [wat_pkg::STATUS_W-1:0]      status,
  output logic [wat_pkg::ID_W-1:0]          new_id,
  output logic [wat_pkg::MASK_W-1:0]        ring_mask,
  output logic [wat_pkg::ID_W-1:0]          ring_count,
  output logic [wat_pkg::ID_W-1:0]          alarm_count
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = ((CNT_W > wat_pkg::ID_W) ? CNT_W : wat_pkg::ID_W) + 1;

  logic [wat_pkg::OP_W-1:0]     op_q;
  logic [wat_pkg::HOUR_W-1:0]   hour_q;
  logic [wat_pkg::MINUTE_W-1:0] minute_q;
  logic                         rep_q;
  logic [wat_pkg::DAYS_W-1:0]   days_q;
  logic [wat_pkg::ID_W-1:0]     id_q;
  logic [wat_pkg::WDAY_W-1:0]   wday_q;

  wat_pkg::wat_entry_t mem [TABLE_DEPTH];
  wat_pkg::wat_entry_t rd_entry;
  wat_pkg::wat_entry_t new_entry;

  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               ptr;
  logic [CNT_W-1:0]               tag;
  logic [CNT_W-1:0]               tag_m1;
  logic                           rd_vld;
  logic [wat_pkg::STATUS_W-1:0]   status_q;
  logic [wat_pkg::ID_W-1:0]       new_id_q;
  logic [wat_pkg::MASK_W-1:0]     mask_q;
  logic [CNT_W-1:0]               ring_q;

  logic [CMP_W-1:0] id_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] tag_ext;
  logic [CNT_W:0]   ptr_inc;
  logic [wat_pkg::DAYS_W:0] day8;
  logic del_ok;
  logic full;
  logic fires;
  logic do_create;

  assign id_ext    = CMP_W'(id_q);
  assign cnt_ext   = CMP_W'(count);
  assign tag_ext   = CMP_W'(tag);
  assign tag_m1    = tag - CNT_W'(1);
  assign ptr_inc   = {1'b0, ptr} + (CNT_W + 1)'(1);
  assign del_ok    = (id_q != '0) && (id_ext <= cnt_ext);
  assign full      = (cnt_ext >= CMP_W'(TABLE_DEPTH));
  assign do_create = cmd.decode && (op_q == wat_pkg::OP_CREATE) && !full;

  // Weekday seven has no day bit and reads the zero on top.
  assign day8  = {1'b0, rd_entry.days};
  assign fires = (rd_entry.hour == hour_q) && (rd_entry.minute == minute_q) &&
                 (rd_entry.rep || day8[wday_q]);

  assign new_entry.days   = days_q;
  assign new_entry.rep    = rep_q;
  assign new_entry.minute = minute_q;
  assign new_entry.hour   = hour_q;

  always_comb begin
    sts.walk = 1'b0;
    if (op_q == wat_pkg::OP_CHECK) begin
      sts.walk = (count != '0);
    end else if (op_q == wat_pkg::OP_DELETE) begin
      sts.walk = del_ok && (id_ext < cnt_ext);
    end
    sts.last = (ptr_inc == {1'b0, count});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
      if (do_create) begin
        count <= count + CNT_W'(1);
      end else if (cmd.finish && (op_q == wat_pkg::OP_DELETE) &&
                   (status_q == wat_pkg::ST_OK)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op;
      hour_q   <= hour;
      minute_q <= minute;
      rep_q    <= repeat_req;
      days_q   <= day_mask;
      id_q     <= alarm_id;
      wday_q   <= weekday;
    end
    if (cmd.decode) begin
      mask_q   <= '0;
      ring_q   <= '0;
      new_id_q <= '0;
      status_q <= wat_pkg::ST_OK;
      // A check walks from the first entry, a delete from the entry after the removed one.
      ptr <= (op_q == wat_pkg::OP_CHECK) ? '0 : CNT_W'(id_q);
      if (op_q == wat_pkg::OP_CREATE) begin
        if (full) begin
          status_q <= wat_pkg::ST_FULL;
        end else begin
          new_id_q <= wat_pkg::ID_W'({1'b0, count} + (CNT_W + 1)'(1));
        end
      end else if (op_q == wat_pkg::OP_DELETE) begin
        if (!del_ok) begin
          status_q <= wat_pkg::ST_NOT_FOUND;
        end
      end
    end else if (rd_vld && (op_q == wat_pkg::OP_CHECK) && fires) begin
      ring_q <= ring_q + CNT_W'(1);
      if (tag_ext < CMP_W'(wat_pkg::MASK_W)) begin
        mask_q <= mask_q | (wat_pkg::MASK_W'(1) << tag_ext[3:0]);
      end
    end
    if (cmd.issue) begin
      ptr <= ptr + CNT_W'(1);
      tag <= ptr;
    end
  end

  // Table storage: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_entry <= mem[ptr[IDX_W-1:0]];
    end
    if (do_create) begin
      mem[count[IDX_W-1:0]] <= new_entry;
    end else if (rd_vld && (op_q == wat_pkg::OP_DELETE)) begin
      mem[tag_m1[IDX_W-1:0]] <= rd_entry;
    end
  end

  assign status      = status_q;
  assign new_id      = new_id_q;
  assign ring_mask   = mask_q;
  assign ring_count  = wat_pkg::ID_W'(ring_q);
  assign alarm_count = wat_pkg::ID_W'(count);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= CMP_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (ptr < count))
    else $error("table read beyond the held entries");

  a_shift_target: assert property (@(posedge clk) disable iff (rst)
    (rd_vld && (op_q == wat_pkg::OP_DELETE)) |-> (tag != '0))
    else $error("delete shift would write below entry zero");

endmodule
